FILE: sv/pjq_pkg.sv
package pjq_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_JOB_LIMIT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_RUNNING = 1'd1;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef struct packed {
        logic        op;
        logic [31:0] job_handle;
        logic [31:0] job_argument;
        logic        has_priority;
        logic [7:0]  job_priority;
    } t_job_in;

    typedef struct packed {
        logic        push_accepted;
        logic [31:0] assigned_id;
        logic        pop_valid;
        logic [31:0] out_handle;
        logic [31:0] out_argument;
        logic        out_has_priority;
        logic [7:0]  out_priority;
        logic [31:0] out_id;
        logic [4:0]  queue_count;
    } t_job_out;

    typedef struct packed {
        logic [31:0] handle;
        logic [31:0] argument;
        logic        has_prio;
        logic [7:0]  prio;
        logic [31:0] id;
    } t_entry;

    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

endpackage

FILE: sv/priority_job_queue.sv
// Priority job queue built as a chain of QUEUE_DEPTH entry cells.
// Input channel (i_in_valid / o_in_stall) carries one beat per command:
// op selects push or pop. Every accepted beat yields exactly one result
// beat on the output channel (o_out_valid / i_out_stall) in the next cycle.
// A push with a priority goes ahead of the first held job with no or a lower
// priority, else to the tail, as does a push without one; it is refused once
// job_limit jobs are held (job_limit 0 or above the depth means the full
// depth). A pop returns the front job only while pool_running is 1.
// Throughput is one beat per cycle while not stalled: every cell compares
// its entry with the new job and moves to or from its neighbor in the same
// cycle, and the result register is refilled in the cycle it drains.
// Configuration: i_cfg_we writes register i_cfg_index (0 job_limit,
// 1 pool_running) at the clock edge; write only while the block is idle.
// Reset (synchronous, i_rst_n low) empties the queue, clears the sequence
// counter and both registers. Entry contents are not cleared.
// While the receiver stalls, the result beat holds and o_in_stall rises, so
// no new command is taken until the pending result is taken.
module priority_job_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  pjq_pkg::t_job_in                    i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output pjq_pkg::t_job_out                   o_out_data,
    input  logic                                i_cfg_we,
    input  logic [pjq_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pjq_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import pjq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int LW = CW + CFG_DATA_W;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [31:0]   r_seq;
    logic [31:0]   n_seq;
    logic [4:0]    r_job_limit;
    logic          r_pool_running;
    logic          r_out_valid;
    t_job_out      r_out;
    t_job_out      n_out;

    logic          w_accept;
    logic [LW-1:0] w_count_ext;
    logic [LW-1:0] w_limit_ext;
    logic [LW-1:0] w_eff_limit;
    logic          w_push_ok;
    logic          w_pop_ok;
    t_entry        w_new;
    t_cell_ctl     w_ctl;
    t_entry        w_entry [QUEUE_DEPTH];
    logic          w_hit   [QUEUE_DEPTH];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_count_ext = {{CFG_DATA_W{1'b0}}, r_count};
    assign w_limit_ext = {{CW{1'b0}}, r_job_limit};
    assign w_eff_limit = ((w_limit_ext == '0) || (w_limit_ext > LW'(QUEUE_DEPTH))) ?
                         LW'(QUEUE_DEPTH) : w_limit_ext;

    assign w_push_ok = w_accept && (i_in_data.op == OP_PUSH) && (w_count_ext < w_eff_limit);
    assign w_pop_ok  = w_accept && (i_in_data.op == OP_POP) && r_pool_running &&
                       (r_count != '0);

    assign w_ctl.push = w_push_ok;
    assign w_ctl.pop  = w_pop_ok;

    always_comb begin
        w_new.handle   = i_in_data.job_handle;
        w_new.argument = i_in_data.job_argument;
        w_new.has_prio = i_in_data.has_priority;
        w_new.prio     = i_in_data.has_priority ? i_in_data.job_priority : 8'd0;
        w_new.id       = r_seq;
    end

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_entry w_prev_entry;
        logic   w_prev_hit;
        t_entry w_next_entry;

        if (g == 0) begin : g_head
            assign w_prev_entry = w_new;
            assign w_prev_hit   = 1'b0;
        end else begin : g_body
            assign w_prev_entry = w_entry[g-1];
            assign w_prev_hit   = w_hit[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign w_next_entry = w_entry[g];
        end else begin : g_mid
            assign w_next_entry = w_entry[g+1];
        end

        pjq_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_count      (r_count),
            .i_new        (w_new),
            .i_prev_entry (w_prev_entry),
            .i_prev_hit   (w_prev_hit),
            .i_next_entry (w_next_entry),
            .o_entry      (w_entry[g]),
            .o_hit        (w_hit[g])
        );
    end

    always_comb begin
        logic [LW-1:0] v_cnt;
        n_count = r_count;
        n_seq   = r_seq;
        if (w_push_ok) begin
            n_count = r_count + CW'(1);
            n_seq   = r_seq + 32'd1;
        end else if (w_pop_ok) begin
            n_count = r_count - CW'(1);
        end

        n_out = '0;
        if (w_push_ok) begin
            n_out.push_accepted = 1'b1;
            n_out.assigned_id   = r_seq;
        end
        if (w_pop_ok) begin
            n_out.pop_valid        = 1'b1;
            n_out.out_handle       = w_entry[0].handle;
            n_out.out_argument     = w_entry[0].argument;
            n_out.out_has_priority = w_entry[0].has_prio;
            n_out.out_priority     = w_entry[0].prio;
            n_out.out_id           = w_entry[0].id;
        end
        v_cnt = {{CFG_DATA_W{1'b0}}, n_count};
        n_out.queue_count = v_cnt[4:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count        <= '0;
            r_seq          <= '0;
            r_job_limit    <= '0;
            r_pool_running <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_count <= n_count;
            r_seq   <= n_seq;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_JOB_LIMIT:    r_job_limit    <= i_cfg_data;
                    CFG_POOL_RUNNING: r_pool_running <= i_cfg_data[0];
                    default: ;
                endcase
            end
            // drain the result beat unless a new one replaces it
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: sv/pjq_cell.sv
module pjq_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic               i_clk,
    input  pjq_pkg::t_cell_ctl i_ctl,
    input  logic [CW-1:0]      i_count,
    input  pjq_pkg::t_entry    i_new,
    input  pjq_pkg::t_entry    i_prev_entry,
    input  logic               i_prev_hit,
    input  pjq_pkg::t_entry    i_next_entry,
    output pjq_pkg::t_entry    o_entry,
    output logic               o_hit
);
    import pjq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    logic   w_held;

    assign w_held = CW'(IDX) < i_count;

    // Queue is sorted so the hit flags along the chain are monotone: the new
    // job lands in the first cell that hits, cells after it shift back.
    assign o_hit = !w_held ||
                   (i_new.has_prio && (!r_entry.has_prio || (r_entry.prio < i_new.prio)));

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.push) begin
            if (i_prev_hit) begin
                n_entry = i_prev_entry;
            end else if (o_hit) begin
                n_entry = i_new;
            end
        end else if (i_ctl.pop) begin
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

FILE: sv/pjq_checker.sv
module pjq_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input pjq_pkg::t_job_out o_out_data
);
    import pjq_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    a_no_stall_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with no pending result");

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.push_accepted && o_out_data.pop_valid))
        else $error("result is both a push and a pop");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.push_accepted |-> o_out_data.queue_count != 5'd0)
        else $error("accepted push left the queue empty");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.push_accepted && !o_out_data.pop_valid |->
        o_out_data.assigned_id == 32'd0 && o_out_data.out_id == 32'd0 &&
        o_out_data.out_handle == 32'd0)
        else $error("empty result carries data");

endmodule

bind priority_job_queue pjq_checker u_pjq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
